// File: hw/rtl/dlpg_pkg.sv
package dlpg_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CMD_DEPTH_DEF  = 4;

  localparam int COLOR_BITS = 8;
  localparam int CFG_BITS   = 2;

  // channel_count code that selects the reversed three-channel mapping
  localparam logic [CFG_BITS-1:0] CHAN_THREE = 2'd3;
  localparam logic [CFG_BITS-1:0] CHAN_RESET = 2'd3;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } dlpg_div_stat_t;

endpackage

// File: hw/rtl/dlpg_fifo.sv
module dlpg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == DEPTH_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/dlpg_front.sv
module dlpg_front #(
  parameter int COORD_BITS = 10,
  parameter int CMD_DEPTH  = 4,
  parameter int CMD_W      = 80
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_kind,
  input  logic [COORD_BITS-1:0]       in_x_start,
  input  logic [COORD_BITS-1:0]       in_y_start,
  input  logic [COORD_BITS-1:0]       in_x_end,
  input  logic [COORD_BITS-1:0]       in_y_end,
  input  logic [dlpg_pkg::COLOR_BITS-1:0] in_color_first,
  input  logic [dlpg_pkg::COLOR_BITS-1:0] in_color_second,
  input  logic [dlpg_pkg::COLOR_BITS-1:0] in_color_third,
  input  logic                        cmd_pop,
  output logic [CMD_W-1:0]            cmd_head,
  output logic                        cmd_empty
);
  import dlpg_pkg::*;

  logic                  neg_x, neg_y;
  logic [COORD_BITS-1:0] ax, ay, steps;
  logic [CMD_W-1:0]      cmd;

  // direction and span of each axis; steps is the major span
  always_comb begin
    neg_x = (in_x_end < in_x_start);
    neg_y = (in_y_end < in_y_start);
    ax    = neg_x ? (in_x_start - in_x_end) : (in_x_end - in_x_start);
    ay    = neg_y ? (in_y_start - in_y_end) : (in_y_end - in_y_start);
    steps = (ax > ay) ? ax : ay;
  end

  assign cmd = {in_kind, in_x_start, in_y_start, neg_x, neg_y, ax, ay, steps,
                in_color_first, in_color_second, in_color_third};

  dlpg_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (cmd),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

endmodule

// File: hw/rtl/dlpg_div.sv
module dlpg_div #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [COORD_BITS-1:0]   dividend,
  input  logic [COORD_BITS-1:0]   divisor,
  output logic [FRAC_BITS:0]      quot,
  output dlpg_pkg::dlpg_div_stat_t stat
);
  import dlpg_pkg::*;

  // quotient of (dividend << FRAC_BITS) / divisor, dividend <= divisor,
  // one restoring step per cycle, FRAC_BITS + 1 steps
  localparam int CNT_W = $clog2(FRAC_BITS + 2);
  localparam logic [CNT_W-1:0] N_STEPS = CNT_W'(FRAC_BITS + 1);

  logic [COORD_BITS:0]   rem_r;
  logic [COORD_BITS-1:0] div_r;
  logic [FRAC_BITS:0]    quot_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r, done_r;

  logic                  ge;
  logic [COORD_BITS:0]   rem_sub;

  always_comb begin
    ge      = (rem_r >= {1'b0, div_r});
    rem_sub = ge ? (rem_r - {1'b0, div_r}) : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= N_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, dividend};
      div_r  <= divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      // remainder stays below divisor, so its top bit is clear before the shift
      rem_r  <= {rem_sub[COORD_BITS-1:0], 1'b0};
      quot_r <= {quot_r[FRAC_BITS-1:0], ge};
    end
  end

  assign quot      = quot_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: hw/rtl/dlpg_back.sv
module dlpg_back #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16,
  parameter int CMD_W      = 80
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [dlpg_pkg::CFG_BITS-1:0] chan_cnt,
  input  logic [CMD_W-1:0]            cmd_head,
  input  logic                        cmd_empty,
  output logic                        cmd_pop,
  output logic                        empty,
  input  logic                        pop,
  output logic [COORD_BITS-1:0]       out_pixel_x,
  output logic [COORD_BITS-1:0]       out_pixel_y,
  output logic [dlpg_pkg::COLOR_BITS-1:0] out_channel_zero,
  output logic [dlpg_pkg::COLOR_BITS-1:0] out_channel_one,
  output logic [dlpg_pkg::COLOR_BITS-1:0] out_channel_two,
  output logic                        out_last_pixel
);
  import dlpg_pkg::*;

  localparam int POS_W = COORD_BITS + FRAC_BITS;

  typedef enum logic {ST_RUN, ST_DIV} state_t;

  // command fields
  logic                  h_kind, h_neg_x, h_neg_y;
  logic [COORD_BITS-1:0] h_xs, h_ys, h_ax, h_ay, h_steps;
  logic [COLOR_BITS-1:0] h_c0, h_c1, h_c2;

  assign {h_kind, h_xs, h_ys, h_neg_x, h_neg_y, h_ax, h_ay, h_steps,
          h_c0, h_c1, h_c2} = cmd_head;

  state_t                state_r, state_nxt;
  logic [POS_W-1:0]      pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [FRAC_BITS:0]    mag_x_r, mag_x_nxt, mag_y_r, mag_y_nxt;
  logic                  neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic [COORD_BITS-1:0] left_r, left_nxt;
  logic [COLOR_BITS-1:0] col0_r, col0_nxt, col1_r, col1_nxt, col2_r, col2_nxt;

  logic                  out_vld_r, out_vld_nxt;
  logic [COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [COLOR_BITS-1:0] ch0_r, ch0_nxt, ch1_r, ch1_nxt, ch2_r, ch2_nxt;
  logic                  last_r, last_nxt;

  logic                  div_start, emit, slot_free, three;
  logic [FRAC_BITS:0]    quot_x, quot_y;
  dlpg_div_stat_t        stat_x, stat_y;
  logic [POS_W-1:0]      inc_x, inc_y;

  assign slot_free = !out_vld_r || pop;
  assign three     = (chan_cnt == CHAN_THREE);
  assign inc_x     = {{(COORD_BITS-1){1'b0}}, mag_x_r};
  assign inc_y     = {{(COORD_BITS-1){1'b0}}, mag_y_r};

  always_comb begin
    state_nxt   = state_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    mag_x_nxt   = mag_x_r;
    mag_y_nxt   = mag_y_r;
    neg_x_nxt   = neg_x_r;
    neg_y_nxt   = neg_y_r;
    left_nxt    = left_r;
    col0_nxt    = col0_r;
    col1_nxt    = col1_r;
    col2_nxt    = col2_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    ch0_nxt     = ch0_r;
    ch1_nxt     = ch1_r;
    ch2_nxt     = ch2_r;
    last_nxt    = last_r;
    cmd_pop     = 1'b0;
    div_start   = 1'b0;
    emit        = 1'b0;

    case (state_r)
      ST_RUN: begin
        if (!cmd_empty) begin
          if (h_kind == KIND_LOAD) begin
            cmd_pop   = 1'b1;
            pos_x_nxt = {h_xs, {FRAC_BITS{1'b0}}};
            pos_y_nxt = {h_ys, {FRAC_BITS{1'b0}}};
            neg_x_nxt = h_neg_x;
            neg_y_nxt = h_neg_y;
            left_nxt  = h_steps;
            col0_nxt  = h_c0;
            col1_nxt  = h_c1;
            col2_nxt  = h_c2;
            mag_x_nxt = '0;
            mag_y_nxt = '0;
            if (h_steps != '0) begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end else if (left_r == '0) begin
            // no line in progress: tick is dropped
            cmd_pop = 1'b1;
          end else if (slot_free) begin
            cmd_pop   = 1'b1;
            emit      = 1'b1;
            px_nxt    = pos_x_r[POS_W-1:FRAC_BITS];
            py_nxt    = pos_y_r[POS_W-1:FRAC_BITS];
            ch0_nxt   = three ? col2_r : col0_r;
            ch1_nxt   = three ? col1_r : '0;
            ch2_nxt   = three ? col0_r : '0;
            last_nxt  = (left_r == COORD_BITS'(1));
            pos_x_nxt = neg_x_r ? (pos_x_r - inc_x) : (pos_x_r + inc_x);
            pos_y_nxt = neg_y_r ? (pos_y_r - inc_y) : (pos_y_r + inc_y);
            left_nxt  = left_r - 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (stat_x.done) begin
          mag_x_nxt = quot_x;
          mag_y_nxt = quot_y;
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase

    out_vld_nxt = (out_vld_r && !pop) || emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      left_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      left_r    <= left_nxt;
      out_vld_r <= out_vld_nxt;
    end
    pos_x_r <= pos_x_nxt;
    pos_y_r <= pos_y_nxt;
    mag_x_r <= mag_x_nxt;
    mag_y_r <= mag_y_nxt;
    neg_x_r <= neg_x_nxt;
    neg_y_r <= neg_y_nxt;
    col0_r  <= col0_nxt;
    col1_r  <= col1_nxt;
    col2_r  <= col2_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    ch0_r   <= ch0_nxt;
    ch1_r   <= ch1_nxt;
    ch2_r   <= ch2_nxt;
    last_r  <= last_nxt;
  end

  dlpg_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (h_ax),
    .divisor  (h_steps),
    .quot     (quot_x),
    .stat     (stat_x)
  );

  dlpg_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (h_ay),
    .divisor  (h_steps),
    .quot     (quot_y),
    .stat     (stat_y)
  );

  assign empty            = !out_vld_r;
  assign out_pixel_x      = px_r;
  assign out_pixel_y      = py_r;
  assign out_channel_zero = ch0_r;
  assign out_channel_one  = ch1_r;
  assign out_channel_two  = ch2_r;
  assign out_last_pixel   = last_r;

  a_no_pop_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !cmd_pop)
    else $error("command consumed during division");

  a_div_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (stat_x.done == stat_y.done) && (stat_x.busy == stat_y.busy))
    else $error("divider lanes out of step");

  a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    stat_x.done |-> (state_r == ST_DIV))
    else $error("division finished outside wait state");

  a_emit_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (left_r == $past(left_r) - 1'b1) && out_vld_r)
    else $error("pixel count not advanced on emit");

endmodule

// File: hw/rtl/dda_line_pixel_generator.sv
// DDA line rasterizer. A load item (in_kind = 0) latches start point, end point
// and three color bytes; each later tick item (in_kind = 1) yields the next pixel
// of the line, walking from the start toward the end in max(|dx|,|dy|) steps with
// per-step increments held in fixed point (FRAC_BITS fraction bits, truncated
// toward zero). The end point is not drawn, a zero-length line yields nothing, and
// ticks with no line in progress are dropped silently. out_last_pixel flags the
// final pixel. With channel_count = 3 the channels carry the color bytes in
// reverse order; any other count puts the first byte on channel zero and zeros on
// the others. Both sides are queues: items go into a CMD_DEPTH-entry command
// queue (full backs up push), results sit in a one-item output register (empty,
// pop). Ticks retire one item per cycle when the consumer keeps popping. A load
// with a nonzero length holds the back end in its wait state while the two
// restoring dividers produce the x and y increments one quotient bit a cycle;
// the queue keeps accepting items meanwhile. Write cfg_wr_data to the channel
// count only while no item is in flight.
module dda_line_pixel_generator #(
  parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dlpg_pkg::FRAC_BITS_DEF,
  parameter int CMD_DEPTH  = dlpg_pkg::CMD_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // config
  input  logic                        cfg_wr_en,
  input  logic [dlpg_pkg::CFG_BITS-1:0] cfg_wr_data,
  // item input
  input  logic                        push,
  output logic                        full,
  input  logic                        in_kind,
  input  logic [COORD_BITS-1:0]       in_x_start,
  input  logic [COORD_BITS-1:0]       in_y_start,
  input  logic [COORD_BITS-1:0]       in_x_end,
  input  logic [COORD_BITS-1:0]       in_y_end,
  input  logic [dlpg_pkg::COLOR_BITS-1:0] in_color_first,
  input  logic [dlpg_pkg::COLOR_BITS-1:0] in_color_second,
  input  logic [dlpg_pkg::COLOR_BITS-1:0] in_color_third,
  // pixel output
  output logic                        empty,
  input  logic                        pop,
  output logic [COORD_BITS-1:0]       out_pixel_x,
  output logic [COORD_BITS-1:0]       out_pixel_y,
  output logic [dlpg_pkg::COLOR_BITS-1:0] out_channel_zero,
  output logic [dlpg_pkg::COLOR_BITS-1:0] out_channel_one,
  output logic [dlpg_pkg::COLOR_BITS-1:0] out_channel_two,
  output logic                        out_last_pixel
);
  import dlpg_pkg::*;

  // command: kind, start x/y, signs, spans, step count, three colors
  localparam int CMD_W = 1 + 5 * COORD_BITS + 2 + 3 * COLOR_BITS;

  logic [CFG_BITS-1:0] chan_cnt_r;
  logic [CMD_W-1:0]    cmd_head;
  logic                cmd_empty, cmd_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= CHAN_RESET;
    end else if (cfg_wr_en) begin
      chan_cnt_r <= cfg_wr_data;
    end
  end

  // front end: span/direction classification into the command queue
  dlpg_front #(
    .COORD_BITS (COORD_BITS),
    .CMD_DEPTH  (CMD_DEPTH),
    .CMD_W      (CMD_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_kind         (in_kind),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .in_color_first  (in_color_first),
    .in_color_second (in_color_second),
    .in_color_third  (in_color_third),
    .cmd_pop         (cmd_pop),
    .cmd_head        (cmd_head),
    .cmd_empty       (cmd_empty)
  );

  // back end: increment division, position stepping, output register
  dlpg_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .CMD_W      (CMD_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .chan_cnt         (chan_cnt_r),
    .cmd_head         (cmd_head),
    .cmd_empty        (cmd_empty),
    .cmd_pop          (cmd_pop),
    .empty            (empty),
    .pop              (pop),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_channel_zero (out_channel_zero),
    .out_channel_one  (out_channel_one),
    .out_channel_two  (out_channel_two),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

// File: sim/tb_dda_line_pixel_generator.sv
module tb_dda_line_pixel_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import dlpg_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int FW = FRAC_BITS_DEF;
  localparam int CB = COLOR_BITS;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};

  // After the last pixel is popped, loads and dead ticks may still sit in the
  // command queue: each load can hold the back end while its division runs.
  localparam int SETTLE_CYCLES = CMD_DEPTH_DEF * (FW + 2) + 40;
  // Cycles with no item moving on either side before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Long receiver hold-off used to back the block up to a full input queue.
  localparam int HOLD_CYCLES = 400;

  // One input item as the sender sees it.
  typedef struct packed {
    logic          kind;
    logic [CW-1:0] xs;
    logic [CW-1:0] ys;
    logic [CW-1:0] xe;
    logic [CW-1:0] ye;
    logic [CB-1:0] c1;
    logic [CB-1:0] c2;
    logic [CB-1:0] c3;
  } raster_cmd_t;

  // One pixel as it should leave the block.
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CB-1:0] ch0;
    logic [CB-1:0] ch1;
    logic [CB-1:0] ch2;
    logic          last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_BITS-1:0] cfg_wr_data;
  logic push;
  logic full;
  logic in_kind;
  logic [CW-1:0] in_x_start, in_y_start, in_x_end, in_y_end;
  logic [CB-1:0] in_color_first, in_color_second, in_color_third;
  logic empty;
  logic pop;
  logic [CW-1:0] out_pixel_x, out_pixel_y;
  logic [CB-1:0] out_channel_zero, out_channel_one, out_channel_two;
  logic out_last_pixel;

  dda_line_pixel_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .push            (push),
    .full            (full),
    .in_kind         (in_kind),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .in_color_first  (in_color_first),
    .in_color_second (in_color_second),
    .in_color_third  (in_color_third),
    .empty           (empty),
    .pop             (pop),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_channel_zero(out_channel_zero),
    .out_channel_one (out_channel_one),
    .out_channel_two (out_channel_two),
    .out_last_pixel  (out_last_pixel)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Line walker model: its own copy of the block's state and channel count.
  // ---------------------------------------------------------------------------
  logic [CFG_BITS-1:0] model_chan;
  longint              walk_x, walk_y;     // position, FW fraction bits
  longint              inc_x, inc_y;       // signed per-step increments
  longint              pixels_left;
  logic [CB-1:0]       line_color [3];

  pixel_t pending_pixels[$];               // pixels owed by the block, oldest first

  int unsigned errors = 0;
  int unsigned n_items = 0, n_loads = 0, n_ticks = 0;
  int unsigned n_pixels = 0, n_line_ends = 0, n_full_cycles = 0;

  // Sender / receiver pacing controls, shared with the test tasks.
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int unsigned rx_hold = 0;
  int unsigned rx_wait = 0;

  // Increment for one axis: (d << FW) / span, truncated toward zero.
  function automatic longint axis_increment(longint d, longint span);
    longint mag, q;
    if (span == 0) return 0;
    mag = (d < 0) ? -d : d;
    q = (mag << FW) / span;
    return (d < 0) ? -q : q;
  endfunction

  // Apply one accepted item to the model; a live tick owes one pixel.
  function automatic void advance_raster(raster_cmd_t c);
    longint dx, dy, ax, ay, span;
    pixel_t p;
    if (c.kind == KIND_LOAD) begin
      n_loads++;
      dx = longint'(c.xe) - longint'(c.xs);
      dy = longint'(c.ye) - longint'(c.ys);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      span = (ax > ay) ? ax : ay;
      walk_x = longint'(c.xs) << FW;
      walk_y = longint'(c.ys) << FW;
      inc_x = axis_increment(dx, span);
      inc_y = axis_increment(dy, span);
      pixels_left = span;
      line_color[0] = c.c1;
      line_color[1] = c.c2;
      line_color[2] = c.c3;
    end else begin
      n_ticks++;
      if (pixels_left != 0) begin
        p.x = CW'(walk_x >> FW);
        p.y = CW'(walk_y >> FW);
        // three channels: reversed byte order; otherwise first byte only
        if (model_chan == CHAN_THREE) begin
          p.ch0 = line_color[2];
          p.ch1 = line_color[1];
          p.ch2 = line_color[0];
        end else begin
          p.ch0 = line_color[0];
          p.ch1 = '0;
          p.ch2 = '0;
        end
        p.last = (pixels_left == 1);
        pending_pixels.push_back(p);
        walk_x += inc_x;
        walk_y += inc_y;
        pixels_left--;
      end
    end
  endfunction

  // Mostly back-to-back, often a few cycles, now and then a long gap.
  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic raster_cmd_t random_cmd(logic kind);
    raster_cmd_t c;
    c.kind = kind;
    c.xs = CW'($urandom);
    c.ys = CW'($urandom);
    c.xe = CW'($urandom);
    c.ye = CW'($urandom);
    c.c1 = CB'($urandom);
    c.c2 = CB'($urandom);
    c.c3 = CB'($urandom);
    return c;
  endfunction

  // Ticks carry random junk on the coordinate and color fields.
  function automatic raster_cmd_t tick_cmd();
    return random_cmd(KIND_TICK);
  endfunction

  function automatic raster_cmd_t load_cmd(int xs, int ys, int xe, int ye,
                                           int c1, int c2, int c3);
    raster_cmd_t c;
    c.kind = KIND_LOAD;
    c.xs = CW'(xs);
    c.ys = CW'(ys);
    c.xe = CW'(xe);
    c.ye = CW'(ye);
    c.c1 = CB'(c1);
    c.c2 = CB'(c2);
    c.c3 = CB'(c3);
    return c;
  endfunction

  // Endpoint within +-spread of base, clipped to the coordinate range.
  function automatic logic [CW-1:0] nearby(logic [CW-1:0] base, int spread);
    int v;
    v = int'(base) + $urandom_range(2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > int'(CMAX)) v = int'(CMAX);
    return CW'(v);
  endfunction

  // Random start anywhere, end close by; an occasional zero-length line.
  function automatic raster_cmd_t short_line(int spread);
    raster_cmd_t c;
    c = random_cmd(KIND_LOAD);
    if ($urandom_range(15) == 0) begin
      c.xe = c.xs;
      c.ye = c.ys;
    end else begin
      c.xe = nearby(c.xs, spread);
      c.ye = nearby(c.ys, spread);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offer one item until full is seen low at a clock edge, then maybe idle.
  // push stays high when the next item follows at once.
  task automatic send_item(raster_cmd_t c);
    int unsigned gap;
    push            <= 1'b1;
    in_kind         <= c.kind;
    in_x_start      <= c.xs;
    in_y_start      <= c.ys;
    in_x_end        <= c.xe;
    in_y_end        <= c.ye;
    in_color_first  <= c.c1;
    in_color_second <= c.c2;
    in_color_third  <= c.c3;
    do begin
      @(posedge clk);
      if (full !== 1'b0) n_full_cycles++;
    end while (full !== 1'b0);
    n_items++;
    advance_raster(c);
    gap = pick_gap(tx_steady);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering, let every owed pixel come out, then let dead items retire.
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic set_channel_count(logic [CFG_BITS-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_chan = v;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: checks each popped pixel, then picks its next stall.
  // ---------------------------------------------------------------------------
  function automatic void check_pixel();
    pixel_t e;
    if (pending_pixels.size() == 0) begin
      $error("pixel with none expected: x=%0d y=%0d", out_pixel_x, out_pixel_y);
      errors++;
      return;
    end
    e = pending_pixels.pop_front();
    n_pixels++;
    if (e.last) n_line_ends++;
    if (out_pixel_x !== e.x) begin
      $error("pixel_x: expected %0d, got %0d", e.x, out_pixel_x);
      errors++;
    end
    if (out_pixel_y !== e.y) begin
      $error("pixel_y: expected %0d, got %0d", e.y, out_pixel_y);
      errors++;
    end
    if (out_channel_zero !== e.ch0) begin
      $error("channel_zero: expected %0d, got %0d", e.ch0, out_channel_zero);
      errors++;
    end
    if (out_channel_one !== e.ch1) begin
      $error("channel_one: expected %0d, got %0d", e.ch1, out_channel_one);
      errors++;
    end
    if (out_channel_two !== e.ch2) begin
      $error("channel_two: expected %0d, got %0d", e.ch2, out_channel_two);
      errors++;
    end
    if (out_last_pixel !== e.last) begin
      $error("last_pixel: expected %0d, got %0d", e.last, out_last_pixel);
      errors++;
    end
  endfunction

  // Outputs are read as they stood before the edge; pop is driven after it.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && pop && empty === 1'b0) check_pixel();
    if (rst_n !== 1'b1) begin
      pop <= 1'b0;
    end else if (rx_hold != 0) begin
      // long hold-off requested by a test, counted down here
      pop <= 1'b0;
      rx_hold--;
    end else if (rx_wait != 0) begin
      pop <= 1'b0;
      rx_wait--;
    end else begin
      pop <= 1'b1;
      if (pop && empty === 1'b0) rx_wait = pick_gap(rx_steady);
    end
  end

  // Watchdog: ends the run if nothing moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && full === 1'b0) || (pop && empty === 1'b0)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no item moved for %0d cycles, %0d pixels still owed",
             WATCHDOG_LIMIT, pending_pixels.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Ticks straight out of reset: no line loaded, nothing may come out.
  task automatic test_idle_ticks();
    repeat (2) send_item(tick_cmd());
  endtask

  // Corner to corner both ways, each cut short by the next load.
  task automatic test_extreme_lines();
    send_item(load_cmd(CMAX, 0, 0, CMAX, 8'hff, 8'h00, 8'h80));
    repeat (3) send_item(tick_cmd());
    send_item(load_cmd(0, CMAX, CMAX, 0, 8'h00, 8'hff, 8'h7f));
    repeat (3) send_item(tick_cmd());
  endtask

  // Zero length, run-off past the end, and both negative directions.
  task automatic test_short_lines();
    send_item(load_cmd(5, 5, 5, 5, 8'h11, 8'h22, 8'h33));
    send_item(tick_cmd());
    // three pixels, then a tick after the line is done
    send_item(load_cmd(10, 20, 13, 21, 8'h12, 8'h34, 8'h56));
    repeat (4) send_item(tick_cmd());
    // x walking down
    send_item(load_cmd(7, 3, 4, 3, 8'h01, 8'h80, 8'hfe));
    repeat (3) send_item(tick_cmd());
    // y major, both axes decreasing
    send_item(load_cmd(500, 600, 499, 598, 8'haa, 8'h55, 8'hc3));
    repeat (2) send_item(tick_cmd());
  endtask

  // Every channel count, each with a short line walked to its end.
  task automatic test_channel_map();
    raster_cmd_t c;
    for (int cc = 0; cc < 4; cc++) begin
      wait_drained();
      set_channel_count(CFG_BITS'(cc));
      c = short_line(4);
      send_item(c);
      repeat (pixels_left + 1) send_item(tick_cmd());
    end
  endtask

  // Receiver holds off while the sender keeps pushing: the queue fills and
  // full must throttle the sender. The sender pauses for a full drain on
  // both sides of this.
  task automatic test_backpressure();
    wait_drained();
    tx_steady = 1'b1;
    rx_hold = HOLD_CYCLES;
    send_item(load_cmd(100, 200, 140, 190, 8'h5a, 8'ha5, 8'h3c));
    repeat (44) send_item(tick_cmd());
    tx_steady = 1'b0;
    wait_drained();
  endtask

  // Mostly well-formed lines walked to (or just past) the end; some cut short,
  // some long lines ticked a little, some noise.
  task automatic random_burst();
    int unsigned r;
    longint n;
    raster_cmd_t c;
    r = $urandom_range(99);
    if (r < 75) begin
      c = short_line(12);
      send_item(c);
      if ($urandom_range(9) == 0) n = $urandom_range(int'(pixels_left));
      else n = pixels_left + $urandom_range(2);
      repeat (n) send_item(tick_cmd());
    end else if (r < 85) begin
      send_item(random_cmd(KIND_LOAD));
      repeat ($urandom_range(8, 1)) send_item(tick_cmd());
    end else begin
      repeat ($urandom_range(4, 1)) send_item(random_cmd(logic'($urandom_range(1))));
    end
  endtask

  task automatic test_random();
    logic [CFG_BITS-1:0] phase_chan [6];
    int unsigned mark;
    phase_chan = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0};
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      set_channel_count(phase_chan[ph]);
      // one phase fully back-to-back, another with a free-running receiver
      tx_steady = (ph == 2);
      rx_steady = (ph == 2) || (ph == 4);
      mark = n_items;
      while (n_items - mark < 50) random_burst();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    push            = 1'b0;
    in_kind         = KIND_LOAD;
    in_x_start      = '0;
    in_y_start      = '0;
    in_x_end        = '0;
    in_y_end        = '0;
    in_color_first  = '0;
    in_color_second = '0;
    in_color_third  = '0;

    // model reset state
    model_chan    = CHAN_RESET;
    walk_x        = 0;
    walk_y        = 0;
    inc_x         = 0;
    inc_y         = 0;
    pixels_left   = 0;
    line_color[0] = '0;
    line_color[1] = '0;
    line_color[2] = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_extreme_lines();
    test_short_lines();
    test_channel_map();
    test_backpressure();
    test_random();

    wait_drained();

    $display("covered %0d items (%0d loads, %0d ticks); %0d pixels checked, %0d line ends",
             n_items, n_loads, n_ticks, n_pixels, n_line_ends);
    $display("all four channel counts used; input held off by full for %0d cycles",
             n_full_cycles);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (pending_pixels.size() != 0)
        $error("%0d expected pixels never arrived", pending_pixels.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/dlpg_pkg.sv
hw/rtl/dlpg_fifo.sv
hw/rtl/dlpg_front.sv
hw/rtl/dlpg_div.sv
hw/rtl/dlpg_back.sv
hw/rtl/dda_line_pixel_generator.sv
sim/tb_dda_line_pixel_generator.sv
